[hw/rtl/sexp_pkg.sv]
// shared types, codes and byte classes for the s-expression tokenizer
package sexp_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_NUM   = 5'b00010,
    MODE_IDENT = 5'b00100,
    MODE_SIGN  = 5'b01000,
    MODE_HALT  = 5'b10000
  } mode_t;

  localparam logic [2:0] KIND_LPAREN  = 3'd0;
  localparam logic [2:0] KIND_RPAREN  = 3'd1;
  localparam logic [2:0] KIND_COMMA   = 3'd2;
  localparam logic [2:0] KIND_IDENT   = 3'd3;
  localparam logic [2:0] KIND_NUMBER  = 3'd4;
  localparam logic [2:0] KIND_EOF     = 3'd5;
  localparam logic [2:0] KIND_INVALID = 3'd6;
  localparam logic [2:0] KIND_BADSIGN = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text_byte;
    logic       has_byte;
    logic       token_first;
    logic       token_end;
  } res_t;

  // one accepted byte's results: one, or two when two is set
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic  emit;
    res_t  res;
    mode_t mode;
    logic  sign;
  } fresh_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] b, logic has,
                                  logic first, logic last_tok);
    res_t r;
    r.kind        = kind;
    r.text_byte   = b;
    r.has_byte    = has;
    r.token_first = first;
    r.token_end   = last_tok;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_initial(logic [7:0] c);
    logic r;
    r = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    case (c)
      8'h21, 8'h24, 8'h25, 8'h26, 8'h2a, 8'h2f, 8'h3a,
      8'h3c, 8'h3d, 8'h3e, 8'h3f, 8'h5e, 8'h5f, 8'h7e: r = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic is_subsequent(logic [7:0] c);
    return is_digit(c) || (c == 8'h2b) || (c == 8'h2d) || (c == 8'h2e) ||
           (c == 8'h40) || is_initial(c);
  endfunction

  function automatic logic is_delimiter(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a) ||
           (c == 8'h28) || (c == 8'h29) || (c == 8'h22) || (c == 8'h3b);
  endfunction

  // byte seen with no run open
  function automatic fresh_t fresh_byte(logic [7:0] c, logic sign_in);
    fresh_t f;
    f.emit = 1'b0;
    f.res  = mk_res(KIND_INVALID, 8'h00, 1'b0, 1'b1, 1'b1);
    f.mode = MODE_IDLE;
    f.sign = sign_in;
    case (c)
      8'h20, 8'h09, 8'h0d, 8'h0a: ;
      8'h2c: begin
        f.emit = 1'b1;
        f.res  = mk_res(KIND_COMMA, c, 1'b1, 1'b1, 1'b1);
      end
      8'h28: begin
        f.emit = 1'b1;
        f.res  = mk_res(KIND_LPAREN, c, 1'b1, 1'b1, 1'b1);
      end
      8'h29: begin
        f.emit = 1'b1;
        f.res  = mk_res(KIND_RPAREN, c, 1'b1, 1'b1, 1'b1);
      end
      8'h2b, 8'h2d: begin
        f.mode = MODE_SIGN;
        f.sign = (c == 8'h2d);
      end
      default: begin
        f.emit = 1'b1;
        if (is_digit(c)) begin
          f.mode = MODE_NUM;
          f.res  = mk_res(KIND_NUMBER, c, 1'b1, 1'b1, 1'b0);
        end else if (is_initial(c)) begin
          f.mode = MODE_IDENT;
          f.res  = mk_res(KIND_IDENT, c, 1'b1, 1'b1, 1'b0);
        end else begin
          f.mode = MODE_HALT;
        end
      end
    endcase
    return f;
  endfunction

endpackage

[hw/rtl/sexp_front.sv]
// front end: takes bytes, classifies them and tracks the lexer mode
module sexp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_input_byte,
  input  logic                in_end_of_input,
  input  logic                q_full,
  output logic                q_push,
  output sexp_pkg::entry_t    q_data
);
  import sexp_pkg::*;

  mode_t  mode_r, mode_nxt;
  logic   sign_r, sign_nxt;
  logic   emit;
  entry_t ent;
  fresh_t f;
  logic   acc;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign q_push   = acc && emit;
  assign q_data   = ent;

  always_comb begin
    mode_nxt = mode_r;
    sign_nxt = sign_r;
    emit     = 1'b0;
    ent.two  = 1'b0;
    ent.r0   = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1);
    ent.r1   = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1);
    f        = fresh_byte(in_input_byte, sign_r);
    case (mode_r)
      MODE_IDLE: begin
        if (in_end_of_input) begin
          emit = 1'b1;
        end else begin
          emit     = f.emit;
          ent.r0   = f.res;
          mode_nxt = f.mode;
          sign_nxt = f.sign;
        end
      end
      MODE_NUM, MODE_IDENT: begin
        emit   = 1'b1;
        // run close result
        ent.r0 = mk_res((mode_r == MODE_NUM) ? KIND_NUMBER : KIND_IDENT,
                        8'h00, 1'b0, 1'b0, 1'b1);
        if (in_end_of_input) begin
          ent.two  = 1'b1;
          mode_nxt = MODE_IDLE;
        end else if ((mode_r == MODE_NUM) ? is_digit(in_input_byte)
                                           : is_subsequent(in_input_byte)) begin
          ent.r0.text_byte = in_input_byte;
          ent.r0.has_byte  = 1'b1;
          ent.r0.token_end = 1'b0;
        end else begin
          ent.two  = f.emit;
          ent.r1   = f.res;
          mode_nxt = f.mode;
          sign_nxt = f.sign;
        end
      end
      MODE_SIGN: begin
        emit = 1'b1;
        if (in_end_of_input || !is_delimiter(in_input_byte)) begin
          ent.r0   = mk_res(KIND_BADSIGN, 8'h00, 1'b0, 1'b1, 1'b1);
          mode_nxt = MODE_HALT;
        end else begin
          ent.r0   = mk_res(KIND_IDENT, sign_r ? 8'h2d : 8'h2b, 1'b1, 1'b1, 1'b1);
          ent.two  = f.emit;
          ent.r1   = f.res;
          mode_nxt = f.mode;
          sign_nxt = f.sign;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      sign_r <= 1'b0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      sign_r <= sign_nxt;
    end
  end

endmodule

[hw/rtl/sexp_queue.sv]
// small fifo of result entries between front and back
module sexp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sexp_pkg::entry_t    push_data,
  output logic                full,
  output logic                pop_valid,
  input  logic                pop,
  output sexp_pkg::entry_t    pop_data
);
  import sexp_pkg::*;

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/sexp_back.sv]
// back end: plays each entry out as one or two result words
module sexp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sexp_pkg::entry_t    q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_text_byte,
  output logic                out_has_byte,
  output logic                out_token_first,
  output logic                out_token_end,
  output logic                out_last_result
);
  import sexp_pkg::*;

  entry_t cur_r;
  logic   busy_r, busy_nxt;
  logic   idx_r, idx_nxt;
  logic   last;
  res_t   res;

  assign last  = !cur_r.two || idx_r;
  assign q_pop = q_valid && (!busy_r || (out_ready && last));
  assign res   = idx_r ? cur_r.r1 : cur_r.r0;

  assign out_valid       = busy_r;
  assign out_kind        = res.kind;
  assign out_text_byte   = res.text_byte;
  assign out_has_byte    = res.has_byte;
  assign out_token_first = res.token_first;
  assign out_token_end   = res.token_end;
  assign out_last_result = last;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 1'b0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_nxt = 1'b0;
        idx_nxt  = 1'b0;
      end else begin
        idx_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

endmodule

[hw/rtl/s_expression_tokenizer.sv]
// top level of the s-expression tokenizer
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   input_byte, end_of_input
//   out_     output     out_valid / out_ready kind, text_byte, has_byte,
//                                             token_first, token_end, last_result
//
// one byte is accepted per cycle while the entry fifo has room; the front
// classifies it and updates the lexer mode in that same cycle.
// the back sends one result word per cycle while out_ready is high, so a
// byte that closes a run and starts another token gives two words; the
// fifo absorbs the difference. the fifo and then the back register each entry.
// synchronous active-low reset returns to idle with no sign held; after an
// error the block keeps taking bytes but gives no results until reset.
module s_expression_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_input_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_text_byte,
  output logic       out_has_byte,
  output logic       out_token_first,
  output logic       out_token_end,
  output logic       out_last_result
);
  import sexp_pkg::*;

  logic   q_full, q_push, q_valid, q_pop;
  entry_t q_wdata, q_rdata;

  sexp_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_input_byte   (in_input_byte),
    .in_end_of_input (in_end_of_input),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_data          (q_wdata)
  );

  sexp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_rdata)
  );

  sexp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_text_byte   (out_text_byte),
    .out_has_byte    (out_has_byte),
    .out_token_first (out_token_first),
    .out_token_end   (out_token_end),
    .out_last_result (out_last_result)
  );

endmodule
